### rtl/core/quad_encoder_pid_four_wheels_top_defines.svh
// Assertion macros for the quadrature encoder PID block.
// Included by the checker module; expects clk and arst_n in scope.
`ifndef QUAD_ENCODER_PID_FOUR_WHEELS_TOP_DEFINES_SVH
`define QUAD_ENCODER_PID_FOUR_WHEELS_TOP_DEFINES_SVH

// Generic concurrent check, sampled on clk and idle during reset.
`define QEP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A signal keeps its value in the cycle after cond was seen.
`define QEP_ASSERT_HOLD(lbl, cond, sig, msg) \
	`QEP_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

### rtl/core/qep_pkg.sv
// Shared types and constants of the quadrature encoder PID block.
// No dependencies; imported by every module of the block.
package qep_pkg;

	localparam int CMD_W     = 3;
	localparam int WHEEL_W   = 2;
	localparam int TARGET_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int SPEED_W   = 16;
	localparam int DIST_W    = 32;
	localparam int INTEG_W   = 32;
	localparam int DRIVE_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_WHEELS_DEF = 4;
	localparam int COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [CMD_W-1:0] {
		CMD_EDGE       = 3'd0,
		CMD_TICK       = 3'd1,
		CMD_SET_TARGET = 3'd2,
		CMD_RESET_CTRL = 3'd3,
		CMD_CLEAR_DIST = 3'd4
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ERR,
		BK_MUL,
		BK_SUM
	} back_state_t;

	typedef struct packed {
		cmd_t                        cmd;
		logic [WHEEL_W-1:0]          wheel;
		logic                        channel;
		logic                        level;
		logic signed [TARGET_W-1:0]  target;
	} op_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop;
		logic signed [GAIN_W-1:0] integ;
		logic signed [GAIN_W-1:0] deriv;
	} gains_t;

	typedef struct packed {
		logic [WHEEL_W-1:0]        wheel;
		logic signed [SPEED_W-1:0] speed;
		logic signed [DIST_W-1:0]  distance;
		logic signed [DRIVE_W-1:0] drive;
		logic                      last;
	} result_t;

endpackage

### rtl/core/qep_front.sv
// Front end: takes requests from the input stream, drops those that do nothing
// and pushes the rest as decoded operations into the queue. Uses qep_pkg.
module qep_front import qep_pkg::*; #(
	parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // wheel, channel, level, target, zero pad
	input  logic [CMD_W-1:0]     s_tuser,  // command
	input  logic                 q_full,
	output logic                 q_push,
	output op_t                  q_op
);

	logic keep;
	logic wheel_ok;

	assign wheel_ok = (int'(s_tdata[WHEEL_W-1:0]) < NUM_WHEELS);

	always_comb begin
		unique case (s_tuser) inside
			CMD_TICK: keep = 1'b1;
			CMD_EDGE, CMD_SET_TARGET, CMD_RESET_CTRL, CMD_CLEAR_DIST: keep = wheel_ok;
			default: keep = 1'b0;
		endcase
	end

	// Dropped requests are still taken so the stream never blocks on them.
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && keep;

	assign q_op.cmd     = cmd_t'(s_tuser);
	assign q_op.wheel   = s_tdata[WHEEL_W-1:0];
	assign q_op.channel = s_tdata[WHEEL_W];
	assign q_op.level   = s_tdata[WHEEL_W+1];
	assign q_op.target  = s_tdata[WHEEL_W+2 +: TARGET_W];

endmodule

### rtl/core/qep_queue.sv
// Small FIFO of decoded operations between front and back end.
// Uses op_t from qep_pkg.
module qep_queue import qep_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  pop_op,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/qep_back.sv
// Back end: per-wheel encoder and PID state, the three-step PID datapath
// and the result register. Uses qep_pkg.
module qep_back import qep_pkg::*; #(
	parameter int NUM_WHEELS = NUM_WHEELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  gains_t  gains,
	input  logic    q_empty,
	input  op_t     q_op,
	output logic    q_pop,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int IDX_W  = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
	localparam int ERR_W  = ((COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W) + 1;
	localparam int IS_W   = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
	localparam int DER_W  = ERR_W + 1;
	localparam int PP_W   = GAIN_W + ERR_W;
	localparam int PI_W   = GAIN_W + INTEG_W;
	localparam int PD_W   = GAIN_W + DER_W;
	localparam int SUM_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic signed [DIST_W-1:0]     DST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0]     DST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// Per-wheel state.
	logic                        a_lvl_q   [NUM_WHEELS];
	logic                        b_lvl_q   [NUM_WHEELS];
	logic signed [COUNT_BITS-1:0] cnt_q    [NUM_WHEELS];
	logic signed [DIST_W-1:0]    dist_q    [NUM_WHEELS];
	logic signed [TARGET_W-1:0]  tgt_q     [NUM_WHEELS];
	logic signed [INTEG_W-1:0]   integ_q   [NUM_WHEELS];
	logic signed [ERR_W-1:0]     prev_q    [NUM_WHEELS];
	logic signed [DRIVE_W-1:0]   drive_q   [NUM_WHEELS];
	logic signed [COUNT_BITS-1:0] speed_q  [NUM_WHEELS];

	back_state_t      state_q, state_d;
	logic [IDX_W-1:0] tick_idx_q;
	logic [IDX_W-1:0] idx;
	logic             out_free;
	logic             load_op;
	logic             load_pid;
	logic             last_wheel;

	// Datapath values.
	logic                         na, nb, do_step;
	logic signed [COUNT_BITS-1:0] cnt_cur, cnt_step;
	logic signed [DIST_W-1:0]     dist_cur, dist_step, dist_res;
	logic signed [ERR_W-1:0]      err;
	logic signed [IS_W-1:0]       integ_sum;
	logic signed [INTEG_W-1:0]    integ_new;
	logic signed [DER_W-1:0]      der;
	logic signed [SUM_W-1:0]      sum;
	logic signed [DRIVE_W-1:0]    drive_new;

	// Pipeline registers of the PID step.
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [INTEG_W-1:0] integ_s1;
	logic signed [DER_W-1:0]   der_s1;
	logic signed [PP_W-1:0]    pp_s2;
	logic signed [PI_W-1:0]    pi_s2;
	logic signed [PD_W-1:0]    pd_s2;

	result_t res_q;
	logic    res_valid_q;

	assign out_free   = !res_valid_q || res_ready;
	assign idx        = (state_q == BK_IDLE) ? IDX_W'(q_op.wheel) : tick_idx_q;
	assign last_wheel = (tick_idx_q == IDX_W'(NUM_WHEELS - 1));

	// Encoder step: after either edge the count moves only when A equals B.
	always_comb begin
		cnt_cur  = cnt_q[idx];
		dist_cur = dist_q[idx];
		na       = q_op.channel ? a_lvl_q[idx] : q_op.level;
		nb       = q_op.channel ? q_op.level : b_lvl_q[idx];
		do_step  = (na == nb);
		cnt_step = cnt_cur;
		dist_step = dist_cur;
		if (do_step && !q_op.channel) begin
			cnt_step  = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
			dist_step = (dist_cur == DST_MAX) ? dist_cur : dist_cur + DIST_W'(1);
		end else if (do_step) begin
			cnt_step  = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_cur - COUNT_BITS'(1);
			dist_step = (dist_cur == DST_MIN) ? dist_cur : dist_cur - DIST_W'(1);
		end
		case (q_op.cmd)
			CMD_EDGE:       dist_res = dist_step;
			CMD_CLEAR_DIST: dist_res = '0;
			default:        dist_res = dist_cur;
		endcase
	end

	// Error, integral and derivative for the wheel under tick.
	always_comb begin
		err       = ERR_W'(tgt_q[idx]) - ERR_W'(cnt_q[idx]);
		integ_sum = IS_W'(integ_q[idx]) + IS_W'(err);
		if (integ_sum[IS_W-1:INTEG_W-1] == '0 || integ_sum[IS_W-1:INTEG_W-1] == '1) begin
			integ_new = integ_sum[INTEG_W-1:0];
		end else begin
			integ_new = integ_sum[IS_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                             : {1'b0, {(INTEG_W-1){1'b1}}};
		end
		der = DER_W'(err) - DER_W'(prev_q[idx]);
	end

	// Weighted sum of the registered products, saturated to the drive width.
	always_comb begin
		sum = SUM_W'(pp_s2) + SUM_W'(pi_s2) + SUM_W'(pd_s2);
		if (sum[SUM_W-1:DRIVE_W-1] == '0 || sum[SUM_W-1:DRIVE_W-1] == '1) begin
			drive_new = sum[DRIVE_W-1:0];
		end else begin
			drive_new = sum[SUM_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
			                         : {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_pop && q_op.cmd == CMD_TICK) state_d = BK_ERR;
			BK_ERR:  state_d = BK_MUL;
			BK_MUL:  state_d = BK_SUM;
			BK_SUM: begin
				if (out_free) begin
					state_d = last_wheel ? BK_IDLE : BK_ERR;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		load_op  = 1'b0;
		load_pid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop   = !q_empty && out_free;
				load_op = q_pop && (q_op.cmd != CMD_TICK);
			end
			BK_SUM:  load_pid = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			tick_idx_q  <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_WHEELS; i++) begin
				a_lvl_q[i] <= 1'b0;
				b_lvl_q[i] <= 1'b0;
				cnt_q[i]   <= '0;
				dist_q[i]  <= '0;
				tgt_q[i]   <= '0;
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
				drive_q[i] <= '0;
				speed_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load_op || load_pid) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_op.cmd)
					CMD_EDGE: begin
						a_lvl_q[idx] <= na;
						b_lvl_q[idx] <= nb;
						cnt_q[idx]   <= cnt_step;
						dist_q[idx]  <= dist_step;
					end
					CMD_SET_TARGET: tgt_q[idx] <= q_op.target;
					CMD_RESET_CTRL: begin
						cnt_q[idx]   <= '0;
						integ_q[idx] <= '0;
						prev_q[idx]  <= '0;
					end
					CMD_CLEAR_DIST: dist_q[idx] <= '0;
					CMD_TICK:       tick_idx_q <= '0;
					default: ;
				endcase
			end
			if (state_q == BK_ERR) begin
				integ_q[idx] <= integ_new;
				prev_q[idx]  <= err;
				speed_q[idx] <= cnt_q[idx];
				cnt_q[idx]   <= '0;
			end
			if (load_pid) begin
				drive_q[idx] <= drive_new;
				if (!last_wheel) begin
					tick_idx_q <= tick_idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_ERR) begin
			err_s1   <= err;
			integ_s1 <= integ_new;
			der_s1   <= der;
		end
		if (state_q == BK_MUL) begin
			pp_s2 <= gains.prop * err_s1;
			pi_s2 <= gains.integ * integ_s1;
			pd_s2 <= gains.deriv * der_s1;
		end
		if (load_op) begin
			res_q.wheel    <= WHEEL_W'(idx);
			res_q.speed    <= SPEED_W'(speed_q[idx]);
			res_q.distance <= dist_res;
			res_q.drive    <= drive_q[idx];
			res_q.last     <= 1'b1;
		end else if (load_pid) begin
			res_q.wheel    <= WHEEL_W'(idx);
			res_q.speed    <= SPEED_W'(speed_q[idx]);
			res_q.distance <= dist_q[idx];
			res_q.drive    <= drive_new;
			res_q.last     <= last_wheel;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/quad_encoder_pid_four_wheels_top.sv
// Top level of the four-wheel quadrature encoder with PID speed loops.
// Holds the gain registers; instantiates qep_front, qep_queue and qep_back.
//
//   channel   direction  handshake               payload
//   s_        in         s_tvalid / s_tready     s_tdata, s_tuser (command)
//   m_        out        m_tvalid / m_tready     m_tdata, m_tlast
//   cfg_      in         cfg_wr_en (no wait)     cfg_index, cfg_wdata
//
// An edge, set-target, reset-controller or clear-distance request is popped from
// the queue and gives its result in the result register. A tick is popped and
// then runs each wheel in turn through the error, multiply and sum steps of the
// shared PID datapath. The queue keeps taking requests while a tick runs, until
// it is full. A stalled output holds the back end; reset clears all wheel state
// at once.
module quad_encoder_pid_four_wheels_top import qep_pkg::*; #(
	parameter int NUM_WHEELS = NUM_WHEELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // wheel, channel, level, target, zero pad
	input  logic [CMD_W-1:0]      s_tuser,   // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // out_wheel, measured_speed, distance, drive, pad
	output logic                  m_tlast,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [GAIN_W-1:0]     cfg_wdata
);

	gains_t  gains_q;
	logic    q_push, q_pop, q_full, q_empty;
	op_t     push_op, pop_op;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIN_PROP:  gains_q.prop  <= cfg_wdata;
				REG_GAIN_INTEG: gains_q.integ <= cfg_wdata;
				REG_GAIN_DERIV: gains_q.deriv <= cfg_wdata;
				default: ;
			endcase
		end
	end

	qep_front #(
		.NUM_WHEELS(NUM_WHEELS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_op    (push_op)
	);

	qep_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(push_op),
		.full   (q_full),
		.pop    (q_pop),
		.pop_op (pop_op),
		.empty  (q_empty)
	);

	qep_back #(
		.NUM_WHEELS(NUM_WHEELS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains_q),
		.q_empty  (q_empty),
		.q_op     (pop_op),
		.q_pop    (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {6'b0, res.drive, res.distance, res.speed, res.wheel};
	assign m_tlast = res.last;

endmodule

### rtl/core/qep_checker.sv
// Port-level checks of the quadrature encoder PID block, bound to its top.
// Uses the assertion macros of quad_encoder_pid_four_wheels_top_defines.svh.
`include "quad_encoder_pid_four_wheels_top_defines.svh"

module qep_checker import qep_pkg::*; #(
	parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,   // out_wheel, measured_speed, distance, drive, pad
	input logic                  m_tlast
);

	`QEP_ASSERT(a_out_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`QEP_ASSERT_HOLD(a_out_data_holds, m_tvalid && !m_tready, m_tdata, "result changed while stalled")
	// Only a tick gives more than one result, and its final wheel always closes the run.
	`QEP_ASSERT(a_run_ends_on_last_wheel, m_tvalid && !m_tlast |-> (NUM_WHEELS > 4) || (m_tdata[1:0] != 2'(NUM_WHEELS - 1)), "run not closed on last wheel")
	`QEP_ASSERT(a_wheel_in_range, m_tvalid |-> (NUM_WHEELS >= 4) || (int'(m_tdata[1:0]) < NUM_WHEELS), "result for missing wheel")

endmodule

bind quad_encoder_pid_four_wheels_top qep_checker #(
	.NUM_WHEELS(NUM_WHEELS)
) u_qep_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for quad_encoder_pid_four_wheels_top.
// Drives encoder, tick and control requests, predicts every wheel result and
// compares; depends only on qep_pkg and the top module.
module tb_top;
	import qep_pkg::*;

	localparam int NW = NUM_WHEELS_DEF;
	localparam longint CNT_HI = (64'sd1 <<< (COUNT_BITS_DEF - 1)) - 1;
	localparam longint CNT_LO = -(64'sd1 <<< (COUNT_BITS_DEF - 1));
	localparam longint I32_HI = 64'sd2147483647;
	localparam longint I32_LO = -64'sd2147483648;
	localparam logic CH_A = 1'b0;
	localparam logic CH_B = 1'b1;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
	localparam int SETTLE_CYCLES = 40;
	localparam int LIMIT_CYCLES = 1000000;

	typedef struct {
		logic [CMD_W-1:0]           cmd;
		logic [WHEEL_W-1:0]         wheel;
		logic                       channel;
		logic                       level;
		logic signed [TARGET_W-1:0] target;
	} request_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [GAIN_W-1:0]     cfg_wdata = '0;

	quad_encoder_pid_four_wheels_top uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted wheel state and gains.
	logic   lvl_a[NW], lvl_b[NW];
	longint cnt[NW], dist_cnt[NW], tgt[NW], integ[NW], perr[NW], drv[NW], spd[NW];
	longint kp, ki, kd;

	// Channel levels as the request generator will have left them.
	logic gen_a[NW], gen_b[NW];

	request_t pending_requests[$];
	result_t  expected_results[$];
	request_t next_req, accepted_req;
	result_t  seen, want;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       mismatches = 0;
	int       cycle_count = 0;

	initial begin
		for (int i = 0; i < NW; i++) begin
			lvl_a[i] = 1'b0; lvl_b[i] = 1'b0; gen_a[i] = 1'b0; gen_b[i] = 1'b0;
			cnt[i] = 0; dist_cnt[i] = 0; tgt[i] = 0; integ[i] = 0;
			perr[i] = 0; drv[i] = 0; spd[i] = 0;
		end
		kp = 0; ki = 0; kd = 0;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void push_result(input int w, input bit fin);
		result_t r;
		r.wheel = WHEEL_W'(w);
		r.speed = SPEED_W'(spd[w]);
		r.distance = DIST_W'(dist_cnt[w]);
		r.drive = DRIVE_W'(drv[w]);
		r.last = fin;
		expected_results.push_back(r);
	endfunction

	function automatic void count_step(input int w, input longint d);
		cnt[w] = clamp(cnt[w] + d, CNT_LO, CNT_HI);
		dist_cnt[w] = clamp(dist_cnt[w] + d, I32_LO, I32_HI);
	endfunction

	function automatic void predict_wheel_results(input request_t r);
		int w;
		longint err;
		if (r.cmd == CMD_TICK) begin
			for (int i = 0; i < NW; i++) begin
				err = tgt[i] - cnt[i];
				integ[i] = clamp(integ[i] + err, I32_LO, I32_HI);
				drv[i] = clamp(kp * err + ki * integ[i] + kd * (err - perr[i]), I32_LO, I32_HI);
				perr[i] = err;
				spd[i] = cnt[i];
				cnt[i] = 0;
			end
			for (int i = 0; i < NW; i++)
				push_result(i, i == NW - 1);
			return;
		end
		if (r.cmd > CMD_CLEAR_DIST || r.wheel >= NW)
			return;
		w = r.wheel;
		case (r.cmd)
			CMD_EDGE: begin
				if (r.channel == CH_A) begin
					lvl_a[w] = r.level;
					if (lvl_a[w] == lvl_b[w])
						count_step(w, 1);
				end else begin
					lvl_b[w] = r.level;
					if (lvl_a[w] == lvl_b[w])
						count_step(w, -1);
				end
			end
			CMD_SET_TARGET: tgt[w] = longint'(r.target);
			CMD_RESET_CTRL: begin
				cnt[w] = 0;
				integ[w] = 0;
				perr[w] = 0;
			end
			default: dist_cnt[w] = 0;
		endcase
		push_result(w, 1'b1);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		mismatches++;
		$display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, exp_val);
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_req.cmd = s_tuser;
				accepted_req.wheel = s_tdata[1:0];
				accepted_req.channel = s_tdata[2];
				accepted_req.level = s_tdata[3];
				accepted_req.target = s_tdata[19:4];
				predict_wheel_results(accepted_req);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, next_req.target, next_req.level, next_req.channel,
						next_req.wheel};
					s_tuser <= next_req.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.wheel = m_tdata[1:0];
				seen.speed = m_tdata[17:2];
				seen.distance = m_tdata[49:18];
				seen.drive = m_tdata[81:50];
				seen.last = m_tlast;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, wheel", seen.wheel, '0);
				end else begin
					want = expected_results.pop_front();
					if (seen.wheel != want.wheel)
						report_mismatch("out_wheel", seen.wheel, want.wheel);
					if (seen.speed != want.speed)
						report_mismatch("measured_speed", seen.speed, want.speed);
					if (seen.distance != want.distance)
						report_mismatch("distance", seen.distance, want.distance);
					if (seen.drive != want.drive)
						report_mismatch("drive", seen.drive, want.drive);
					if (seen.last != want.last)
						report_mismatch("last", seen.last, want.last);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic request_t random_request(input logic [CMD_W-1:0] cmd);
		request_t r;
		r.cmd = cmd;
		r.wheel = WHEEL_W'($urandom_range(NW - 1));
		r.channel = 1'($urandom);
		r.level = 1'($urandom);
		r.target = TARGET_W'($urandom);
		return r;
	endfunction

	function automatic void add_request(input request_t r);
		pending_requests.push_back(r);
		if (r.cmd == CMD_EDGE) begin
			if (r.channel == CH_A)
				gen_a[r.wheel] = r.level;
			else
				gen_b[r.wheel] = r.level;
		end
	endfunction

	// One quadrature count on wheel w. A forward count lands on an A edge that
	// brings A level with B, a backward count on such a B edge; the other
	// channel moves first when the two are already level.
	function automatic int quad_step(input int w, input bit fwd);
		request_t r;
		int n;
		n = 1;
		r = random_request(CMD_EDGE);
		r.wheel = WHEEL_W'(w);
		if (gen_a[w] == gen_b[w]) begin
			r.channel = fwd ? CH_B : CH_A;
			r.level = fwd ? !gen_b[w] : !gen_a[w];
			add_request(r);
			n = 2;
		end
		r.channel = fwd ? CH_A : CH_B;
		r.level = fwd ? !gen_a[w] : !gen_b[w];
		add_request(r);
		return n;
	endfunction

	function automatic void add_cmd(input logic [CMD_W-1:0] cmd, input int w,
			input logic [TARGET_W-1:0] tv);
		request_t r;
		r = random_request(cmd);
		r.wheel = WHEEL_W'(w);
		r.target = tv;
		add_request(r);
	endfunction

	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_GAIN_PROP:  kp = longint'($signed(val));
			REG_GAIN_INTEG: ki = longint'($signed(val));
			default:        kd = longint'($signed(val));
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
		// Unknown commands give no result; the front end drops them.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic directed_requests();
		int n;
		request_t r;
		add_cmd(CMD_SET_TARGET, 0, 16'h7FFF);
		add_cmd(CMD_SET_TARGET, 1, 16'h8000);
		add_cmd(CMD_SET_TARGET, 2, 16'h0000);
		add_cmd(CMD_SET_TARGET, 3, 16'h0001);
		n = quad_step(0, 1'b1);
		n = quad_step(0, 1'b1);
		n = quad_step(1, 1'b0);
		n = quad_step(1, 1'b0);
		// Re-asserting a level that A already holds still counts when A equals B.
		r = random_request(CMD_EDGE);
		r.wheel = WHEEL_W'(3);
		r.channel = CH_A;
		r.level = gen_a[3];
		add_request(r);
		add_cmd(CMD_TICK, 0, 16'hFFFF);
		add_cmd(CMD_RESET_CTRL, 0, 16'h0000);
		add_cmd(CMD_CLEAR_DIST, 1, 16'hFFFF);
		for (int c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++)
			add_cmd(CMD_W'(c), $urandom_range(NW - 1), TARGET_W'($urandom));
		n = quad_step(3, 1'b1);
		add_cmd(CMD_TICK, 3, 16'h0000);
	endtask

	task automatic random_requests(input int count);
		int issued;
		int k;
		int w;
		int len;
		bit fwd;
		request_t r;
		issued = 0;
		while (issued < count) begin
			k = $urandom_range(99);
			if (k < 35) begin
				// Well-formed burst of counts in one direction.
				w = $urandom_range(NW - 1);
				fwd = 1'($urandom);
				len = $urandom_range(6, 1);
				for (int i = 0; i < len; i++)
					issued += quad_step(w, fwd);
			end else if (k < 92) begin
				if (k < 50)
					r = random_request(CMD_EDGE);
				else if (k < 65)
					r = random_request(CMD_TICK);
				else if (k < 77)
					r = random_request(CMD_SET_TARGET);
				else if (k < 85)
					r = random_request(CMD_RESET_CTRL);
				else
					r = random_request(CMD_CLEAR_DIST);
				if (r.cmd == CMD_SET_TARGET && $urandom_range(3) == 0)
					r.target = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				add_request(r);
				issued++;
			end else begin
				add_request(random_request(
					CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO))));
			end
		end
	endtask

	initial begin
		logic [GAIN_W-1:0] gp, gi, gd;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20; recv_stall_pct = 47;
					gp = 16'h0100; gi = 16'h0010; gd = 16'hFFC0;
				end
				1: begin
					send_idle_pct = 47; recv_stall_pct = 20;
					gp = 16'h7FFF; gi = 16'h7FFF; gd = 16'h7FFF;
				end
				2: begin
					send_idle_pct = 0; recv_stall_pct = 0;
					gp = 16'h8000; gi = 16'h8000; gd = 16'h8000;
				end
				default: begin
					send_idle_pct = 0; recv_stall_pct = 0;
					gp = GAIN_W'($urandom); gi = GAIN_W'($urandom); gd = GAIN_W'($urandom);
				end
			endcase
			write_gain(REG_GAIN_PROP, gp);
			write_gain(REG_GAIN_INTEG, gi);
			write_gain(REG_GAIN_DERIV, gd);
			if (phase == 0)
				directed_requests();
			random_requests(40);
			wait_idle();
		end
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/qep_pkg.sv
rtl/core/qep_front.sv
rtl/core/qep_queue.sv
rtl/core/qep_back.sv
rtl/core/quad_encoder_pid_four_wheels_top.sv
rtl/core/qep_checker.sv
dv/tb_top.sv
